// ===== rtl/core/tdp_pkg.sv =====
// Package for the trial division primality core.
// Holds widths and the command and status structs shared by controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tdp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int DIV_W       = (VALUE_WIDTH + 1) / 2 + 1;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic next_div;
	} tdp_cmd_t;

	typedef struct packed {
		logic trivial;
		logic trivial_prime;
		logic sq_gt_n;
		logic last_bit;
		logic rem_zero;
	} tdp_stat_t;

endpackage

// ===== rtl/core/tdp_datapath.sv =====
// Datapath: candidate, divisor, divisor square and a restoring remainder unit.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_datapath import tdp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] candidate,
	input  tdp_cmd_t               cmd,
	output tdp_stat_t              stat
);

	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] sq_q;
	logic [VALUE_WIDTH-1:0] sh_q;
	logic [DIV_W-1:0]       d_q;
	logic [DIV_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIV_W:0]         trial;
	logic [DIV_W:0]         diff;
	logic [VALUE_WIDTH-1:0] sq_inc;

	assign trial  = {rem_q, sh_q[VALUE_WIDTH-1]};
	assign diff   = trial - {1'b0, d_q};
	assign sq_inc = {{(VALUE_WIDTH-DIV_W){1'b0}}, d_q} << 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= CNT_W'(VALUE_WIDTH - 1);
		end else if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= candidate;
			d_q  <= DIV_W'(3);
			sq_q <= VALUE_WIDTH'(9);
		end else if (cmd.next_div) begin
			d_q  <= d_q + DIV_W'(2);
			sq_q <= sq_q + sq_inc + VALUE_WIDTH'(4);
		end
		if (cmd.div_start) begin
			sh_q  <= n_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			sh_q <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	always_comb begin
		stat.trivial       = n_q[VALUE_WIDTH-1] || n_q < VALUE_WIDTH'(4) || !n_q[0];
		stat.trivial_prime = !n_q[VALUE_WIDTH-1] && n_q >= VALUE_WIDTH'(2)
			&& n_q < VALUE_WIDTH'(4);
		stat.sq_gt_n       = sq_q > n_q;
		stat.last_bit      = cnt_q == '0;
		stat.rem_zero      = rem_q == '0;
	end

endmodule

// ===== rtl/core/tdp_ctrl.sv =====
// Controller: sequences trivial checks, divisor trials and the result strobe.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_ctrl import tdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  tdp_stat_t stat,
	output tdp_cmd_t  cmd,
	output logic      busy,
	output logic      done,
	output logic      prime_flag
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_EVAL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       done_d;
	logic       flag_q;
	logic       flag_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		flag_d  = flag_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.trivial) begin
					flag_d  = stat.trivial_prime;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (stat.sq_gt_n) begin
					flag_d  = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.last_bit) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.rem_zero) begin
					flag_d  = 1'b0;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = S_CHECK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		flag_q <= flag_d;
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign prime_flag = flag_q;

endmodule

// ===== rtl/core/trial_division_primality_core.sv =====
// Trial division primality core. Negative, small or even values are settled by the trivial
// check; otherwise odd divisors 3, 5, ... are tried while d*d <= n, each by the bit-serial
// remainder loop, stopping when a divisor hits. One transfer at a time; busy holds until done.
// Reset clears the controller to idle with no result pending.
// The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps

module trial_division_primality_core import tdp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   done,
	output logic                   prime_flag
);

	tdp_cmd_t  cmd;
	tdp_stat_t stat;

	tdp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.prime_flag (prime_flag)
	);

	tdp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.candidate (candidate),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== rtl/core/tdp_checker.sv =====
// Port-level checker for the trial division primality core, bound to the top level.
// Depends on the top-level port list only.
`timescale 1ns / 1ps

module tdp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic prime_flag
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_flag_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(prime_flag))
		else $error("prime_flag unknown on done");

endmodule

bind trial_division_primality_core tdp_checker u_tdp_checker (.*);

// ===== dv/trial_division_primality_core_tb.sv =====
// Self-checking testbench for trial_division_primality_core: directed table, then random candidates.
// Predicts the prime flag from the table or by trial division; checks every done strobe in order.
// Depends on tdp_pkg and the core RTL only.
`timescale 1ns / 1ps

module trial_division_primality_core_tb;
	import tdp_pkg::*;

	typedef struct {
		logic [VALUE_WIDTH-1:0] value;
		bit                     known;
		logic                   flag;
	} dir_row_t;

	localparam int DIR_ROWS = 24;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [VALUE_WIDTH-1:0] candidate;
	logic                   done;
	logic                   prime_flag;

	logic     verdict_q [$];
	logic     want_flag;
	int       mismatch_count;
	int       idle_pct;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{32'h8000_0000, 1'b1, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b0},
		'{32'hFFFF_FFFE, 1'b1, 1'b0},
		'{32'd0,         1'b1, 1'b0},
		'{32'd1,         1'b1, 1'b0},
		'{32'd2,         1'b1, 1'b1},
		'{32'd3,         1'b1, 1'b1},
		'{32'd4,         1'b1, 1'b0},
		'{32'd9,         1'b1, 1'b0},
		'{32'd25,        1'b1, 1'b0},
		'{32'd5,         1'b0, 1'b0},
		'{32'd7,         1'b0, 1'b0},
		'{32'd15,        1'b0, 1'b0},
		'{32'd49,        1'b0, 1'b0},
		'{32'd91,        1'b0, 1'b0},
		'{32'd97,        1'b0, 1'b0},
		'{32'd121,       1'b0, 1'b0},
		'{32'd961,       1'b0, 1'b0},
		'{32'd1369,      1'b0, 1'b0},
		'{32'd65521,     1'b0, 1'b0},
		'{32'd65535,     1'b0, 1'b0},
		'{32'd1000003,   1'b0, 1'b0},
		'{32'h7FFF_FFFE, 1'b1, 1'b0},
		'{32'h7FFF_FFFF, 1'b1, 1'b1}
	};

	trial_division_primality_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.candidate  (candidate),
		.done       (done),
		.prime_flag (prime_flag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("[trial_division_primality_core] ERROR");
		$finish;
	end

	function automatic logic trial_divide_is_prime(input logic [VALUE_WIDTH-1:0] value);
		longint unsigned n;
		longint unsigned d;
		if (value[VALUE_WIDTH-1])
			return 1'b0;
		n = longint'(value);
		if (n < 2)
			return 1'b0;
		if (n < 4)
			return 1'b1;
		if (n[0] == 1'b0)
			return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_candidate();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return $urandom_range(0, 1023);
		else if (sel < 75)
			return $urandom_range(0, 65535);
		else if (sel < 80)
			return $urandom_range(0, (1 << 20) - 1);
		else if (sel < 88)
			return $urandom() | 32'h8000_0000;
		else if (sel < 95)
			return $urandom() & 32'h7FFF_FFFE;
		else
			return $urandom_range(0, 715827882) * 3;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic transfer_candidate(input logic [VALUE_WIDTH-1:0] value, input logic flag);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			while (busy) @(negedge clk);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start     <= 1'b1;
		candidate <= value;
		@(posedge clk);
		while (busy) @(posedge clk);
		verdict_q.push_back(flag);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("done strobe with no transfer pending");
			end else begin
				want_flag = verdict_q.pop_front();
				if (prime_flag !== want_flag)
					report_mismatch($sformatf("prime_flag %b, want %b", prime_flag, want_flag));
			end
		end
	end

	initial begin
		logic [VALUE_WIDTH-1:0] value;
		mismatch_count = 0;
		idle_pct       = 0;
		start          = 1'b0;
		candidate      = '0;
		arst_n         = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].known)
				transfer_candidate(dir_rows[i].value, dir_rows[i].flag);
			else
				transfer_candidate(dir_rows[i].value, trial_divide_is_prime(dir_rows[i].value));
		end
		drain_results();

		foreach (dir_rows[p]) begin
			if (p > 3)
				break;
			idle_pct = (p == 1) ? 65 : (p == 3) ? 38 : 0;
			repeat (25) begin
				value = pick_candidate();
				transfer_candidate(value, trial_divide_is_prime(value));
			end
			if (p == 1)
				drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("[trial_division_primality_core] OK");
		else
			$display("[trial_division_primality_core] ERROR");
		$finish;
	end

endmodule
